>>> design/bsd_pkg.sv
// Shared types and constants of the BMP 24-bit stream decoder.
package bsd_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;

	localparam logic [31:0] HEADER_BYTES  = 32'd54;
	localparam logic [15:0] BMP_SIGNATURE = 16'd19778;
	localparam logic [15:0] BPP_24        = 16'd24;
	localparam logic [7:0]  ALPHA         = 8'hFF;

	// byte positions of the header fields
	localparam logic [5:0] OFS_SIG_HI = 6'd1;
	localparam logic [5:0] OFS_DOFF   = 6'd10;
	localparam logic [5:0] OFS_WID    = 6'd18;
	localparam logic [5:0] OFS_HGT    = 6'd22;
	localparam logic [5:0] OFS_BPP    = 6'd28;
	localparam logic [5:0] OFS_COMP   = 6'd30;
	localparam logic [5:0] OFS_LAST   = 6'd53;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_PAD,
		PH_IDLE
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PIXEL       = 3'd0,
		KIND_HEADER      = 3'd1,
		KIND_BAD_SIG     = 3'd2,
		KIND_UNSUPPORTED = 3'd3,
		KIND_TRUNCATED   = 3'd4
	} kind_t;

	// one classified result on its way from front to back
	typedef struct packed {
		kind_t       kind;
		logic [23:0] bgr;
		logic [11:0] col;
		logic [11:0] row;
		logic [12:0] wid;
		logic [12:0] hgt;
		logic        bottom_up;
		logic        last;
	} rec_t;

endpackage

>>> design/bsd_front.sv
// Front end: byte parser, header checks and pixel packing.
module bsd_front import bsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] byte_value,
	input  logic       start_of_file,
	input  logic       end_of_file,
	output logic       rec_push,
	output rec_t       rec
);

	phase_t      phase_q, n_phase, c_phase;
	logic [31:0] ofs_q, n_ofs, c_ofs;
	logic [1:0]  bip_q, n_bip, c_bip;
	logic [11:0] col_q, n_col, c_col;
	logic [11:0] row_q, n_row, c_row;
	logic [1:0]  pad_q, n_pad, c_pad;

	logic [15:0] sig_q, sig_d;
	logic [31:0] doff_q, doff_d;
	logic [31:0] wid_q, wid_d;
	logic [31:0] hgt_q, hgt_d;
	logic [15:0] bpp_q, bpp_d;
	logic [31:0] comp_q, comp_d;
	logic [15:0] pix_q, pix_d;
	logic [12:0] w_q, w_d;
	logic [12:0] h_q, h_d;
	logic        bu_q, bu_d;

	logic [31:0] h_abs;
	logic        hdr_bad;
	logic [5:0]  o6;
	logic [1:0]  ln;
	logic        last_col, last_row, err;

	assign h_abs   = hgt_q[31] ? (~hgt_q + 32'd1) : hgt_q;
	assign hdr_bad = (bpp_q != BPP_24) || (comp_q != 32'd0) || wid_q[31] ||
		(wid_q == 32'd0) || (wid_q > 32'(MAX_WIDTH)) ||
		(h_abs == 32'd0) || (h_abs > 32'(MAX_HEIGHT));

	always_comb begin
		c_phase  = start_of_file ? PH_HEADER : phase_q;
		c_ofs    = start_of_file ? 32'd0 : ofs_q;
		c_bip    = start_of_file ? 2'd0 : bip_q;
		c_col    = start_of_file ? 12'd0 : col_q;
		c_row    = start_of_file ? 12'd0 : row_q;
		c_pad    = start_of_file ? 2'd0 : pad_q;
		n_phase  = c_phase;
		n_ofs    = c_ofs;
		n_bip    = c_bip;
		n_col    = c_col;
		n_row    = c_row;
		n_pad    = c_pad;
		sig_d    = sig_q;
		doff_d   = doff_q;
		wid_d    = wid_q;
		hgt_d    = hgt_q;
		bpp_d    = bpp_q;
		comp_d   = comp_q;
		pix_d    = pix_q;
		w_d      = w_q;
		h_d      = h_q;
		bu_d     = bu_q;
		rec      = '0;
		rec_push = 1'b0;
		err      = 1'b0;
		o6       = c_ofs[5:0];
		ln       = 2'd0;
		last_col = ({1'b0, c_col} + 13'd1) >= w_q;
		last_row = ({1'b0, c_row} + 13'd1) >= h_q;

		if (c_phase != PH_IDLE) begin
			case (c_phase)
				PH_HEADER: begin
					if (o6 <= OFS_SIG_HI) begin
						sig_d[8*o6[0] +: 8] = byte_value;
					end
					if (o6 >= OFS_DOFF && o6 < OFS_DOFF + 6'd4) begin
						ln = 2'(o6 - OFS_DOFF);
						doff_d[8*ln +: 8] = byte_value;
					end
					if (o6 >= OFS_WID && o6 < OFS_WID + 6'd4) begin
						ln = 2'(o6 - OFS_WID);
						wid_d[8*ln +: 8] = byte_value;
					end
					if (o6 >= OFS_HGT && o6 < OFS_HGT + 6'd4) begin
						ln = 2'(o6 - OFS_HGT);
						hgt_d[8*ln +: 8] = byte_value;
					end
					if (o6 >= OFS_BPP && o6 < OFS_BPP + 6'd2) begin
						bpp_d[8*o6[0] +: 8] = byte_value;
					end
					if (o6 >= OFS_COMP && o6 < OFS_COMP + 6'd4) begin
						ln = 2'(o6 - OFS_COMP);
						comp_d[8*ln +: 8] = byte_value;
					end
					if (c_ofs == 32'(OFS_SIG_HI) && sig_d != BMP_SIGNATURE) begin
						rec.kind = KIND_BAD_SIG;
						rec.last = 1'b1;
						rec_push = 1'b1;
						err      = 1'b1;
						n_phase  = PH_IDLE;
					end else if (c_ofs == 32'(OFS_LAST)) begin
						rec_push = 1'b1;
						if (hdr_bad) begin
							rec.kind = KIND_UNSUPPORTED;
							rec.last = 1'b1;
							err      = 1'b1;
							n_phase  = PH_IDLE;
						end else begin
							w_d      = wid_q[12:0];
							h_d      = h_abs[12:0];
							bu_d     = ~hgt_q[31];
							rec.kind = KIND_HEADER;
							rec.wid  = wid_q[12:0];
							rec.hgt  = h_abs[12:0];
							n_phase  = (doff_q > HEADER_BYTES) ? PH_SKIP : PH_PIXELS;
						end
					end
				end
				PH_SKIP: begin
					if ((c_ofs + 32'd1) >= doff_q) begin
						n_phase = PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					if (c_bip == 2'd2) begin
						rec.kind      = KIND_PIXEL;
						rec.bgr       = {byte_value, pix_q};
						rec.col       = c_col;
						rec.row       = c_row;
						rec.wid       = w_q;
						rec.hgt       = h_q;
						rec.bottom_up = bu_q;
						rec.last      = last_col && last_row;
						rec_push      = 1'b1;
						n_bip         = 2'd0;
						if (last_col && last_row) begin
							n_phase = PH_IDLE;
						end else if (last_col) begin
							n_col = 12'd0;
							n_row = c_row + 12'd1;
							// padding per row equals width mod 4
							if (w_q[1:0] != 2'd0) begin
								n_pad   = w_q[1:0];
								n_phase = PH_PAD;
							end
						end else begin
							n_col = c_col + 12'd1;
						end
					end else begin
						if (c_bip == 2'd0) begin
							pix_d[7:0] = byte_value;
						end else begin
							pix_d[15:8] = byte_value;
						end
						n_bip = c_bip + 2'd1;
					end
				end
				PH_PAD: begin
					n_pad = c_pad - 2'd1;
					if (n_pad == 2'd0) begin
						n_phase = PH_PIXELS;
					end
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase

			if (c_ofs != '1) begin
				n_ofs = c_ofs + 32'd1;
			end

			if (end_of_file) begin
				if (!err && n_phase != PH_IDLE) begin
					rec      = '0;
					rec.kind = KIND_TRUNCATED;
					rec.last = 1'b1;
					rec_push = 1'b1;
				end
				n_phase = PH_IDLE;
			end
		end

		if (!acc) begin
			rec_push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			ofs_q   <= 32'd0;
			bip_q   <= 2'd0;
			col_q   <= 12'd0;
			row_q   <= 12'd0;
			pad_q   <= 2'd0;
		end else if (acc) begin
			phase_q <= n_phase;
			ofs_q   <= n_ofs;
			bip_q   <= n_bip;
			col_q   <= n_col;
			row_q   <= n_row;
			pad_q   <= n_pad;
		end
	end

	// header fields: every lane is rewritten before it is read
	always_ff @(posedge clk) begin
		if (acc) begin
			sig_q  <= sig_d;
			doff_q <= doff_d;
			wid_q  <= wid_d;
			hgt_q  <= hgt_d;
			bpp_q  <= bpp_d;
			comp_q <= comp_d;
			pix_q  <= pix_d;
			w_q    <= w_d;
			h_q    <= h_d;
			bu_q   <= bu_d;
		end
	end

endmodule

>>> design/bsd_fifo.sv
// Short register queue between front and back.
module bsd_fifo import bsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t wdata,
	output logic full,
	input  logic pop,
	output rec_t rdata,
	output logic empty
);

	rec_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

>>> design/bsd_back.sv
// Back end: row flip, pixel word assembly and result register.
module bsd_back import bsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rec_t        rec,
	input  logic        rec_empty,
	output logic        rec_pop,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [31:0] pixel_bgra,
	output logic [11:0] column,
	output logic [11:0] row,
	output logic [12:0] image_width,
	output logic [12:0] image_height,
	output logic        last
);

	logic        vld_q;
	logic [2:0]  kind_q;
	logic [31:0] pix_q;
	logic [11:0] col_q, row_q;
	logic [12:0] w_q, h_q;
	logic        last_q;
	logic        is_pix;
	logic [11:0] row_f;

	assign rec_pop = !rec_empty && (!vld_q || pop);
	assign is_pix  = (rec.kind == KIND_PIXEL);
	// bottom-up files: stream row r is image row h-1-r
	assign row_f   = (is_pix && rec.bottom_up) ?
		12'(rec.hgt - 13'd1 - {1'b0, rec.row}) : rec.row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rec_pop) begin
			vld_q <= 1'b1;
		end else if (pop) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			kind_q <= rec.kind;
			pix_q  <= is_pix ? {ALPHA, rec.bgr} : 32'd0;
			col_q  <= rec.col;
			row_q  <= row_f;
			w_q    <= rec.wid;
			h_q    <= rec.hgt;
			last_q <= rec.last;
		end
	end

	assign empty        = !vld_q;
	assign kind         = kind_q;
	assign pixel_bgra   = pix_q;
	assign column       = col_q;
	assign row          = row_q;
	assign image_width  = w_q;
	assign image_height = h_q;
	assign last         = last_q;

endmodule

>>> design/bmp24_stream_decoder_top.sv
// Top level of the BMP 24-bit uncompressed stream decoder.
//
// Usage:
//  - Input queue: drive byte_value, start_of_file, end_of_file with push; a byte
//    is taken on a clock edge with push high and full low. One byte per cycle while full is low.
//  - Result queue: while empty is low the oldest result sits on kind,
//    pixel_bgra, column, row, image_width, image_height and last; it is taken
//    on an edge with pop high. Each byte yields zero or one result.
//  - Path: a result caused by a byte passes two register stages: the queue
//    entry written on the edge that takes the byte, then the result register,
//    loaded from the queue once the receiver has made room in it.
//  - Throughput: one byte per cycle while full is low, set by the parser's state
//    update on every byte taken; results leave at up to one per cycle.
//  - Stalls: a four-entry record queue sits between parser and result register,
//    so bytes keep flowing while the receiver holds pop low; full rises only
//    when that queue and the result register are all occupied.
//  - Reset: arst_n clears the parser to the header phase and empties both
//    queues; the first file after reset needs no start_of_file.
//  - Pixels come out in file order; the back end flips the row number of bottom-up files.
module bmp24_stream_decoder_top import bsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_value,
	input  logic        start_of_file,
	input  logic        end_of_file,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [31:0] pixel_bgra,
	output logic [11:0] column,
	output logic [11:0] row,
	output logic [12:0] image_width,
	output logic [12:0] image_height,
	output logic        last
);

	logic acc;
	logic rec_push, rec_pop, rec_empty;
	rec_t rec_in, rec_out;

	assign acc = push && !full;

	bsd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.byte_value   (byte_value),
		.start_of_file(start_of_file),
		.end_of_file  (end_of_file),
		.rec_push     (rec_push),
		.rec          (rec_in)
	);

	bsd_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rec_push),
		.wdata (rec_in),
		.full  (full),
		.pop   (rec_pop),
		.rdata (rec_out),
		.empty (rec_empty)
	);

	bsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (rec_out),
		.rec_empty   (rec_empty),
		.rec_pop     (rec_pop),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.pixel_bgra  (pixel_bgra),
		.column      (column),
		.row         (row),
		.image_width (image_width),
		.image_height(image_height),
		.last        (last)
	);

endmodule
